// ----- hdl/formant_peak_picker_macros.svh -----
// Assertion macros shared by the formant peak picker RTL.
`ifndef FORMANT_PEAK_PICKER_MACROS_SVH
`define FORMANT_PEAK_PICKER_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define FPP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define FPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/fpp_pkg.sv -----
// Package with the constants and types of the formant peak picker.
`timescale 1ns / 1ps

package fpp_pkg;

    localparam int MAX_BINS          = 1024;
    localparam int MAX_FORMANT_SLOTS = 16;

    localparam int AMP_W   = 16;
    localparam int FD_W    = AMP_W + 1;
    localparam int SD_W    = AMP_W + 2;
    localparam int BIN_W   = $clog2(MAX_BINS + 1);
    localparam int IDX_W   = $clog2(MAX_BINS);
    localparam int COUNT_W = $clog2(MAX_FORMANT_SLOTS + 1);
    localparam int SLOT_W  = 4;

    localparam int START_W = 20;
    localparam int STEP_W  = 16;
    localparam int MAX_W   = 5;
    localparam int CFG_W   = 20;
    localparam int CFG_IDX_W = 2;
    localparam int FREQ_W  = 27;

    localparam int LIM_W  = (MAX_W > COUNT_W) ? MAX_W : COUNT_W;
    localparam int PROD_W = IDX_W + STEP_W;
    localparam int SUM_A_W = ((START_W > PROD_W) ? START_W : PROD_W) + 1;
    localparam int SUM_W  = (SUM_A_W > FREQ_W + 1) ? SUM_A_W : FREQ_W + 1;

    localparam logic [FREQ_W-1:0]  FREQ_MAX        = {FREQ_W{1'b1}};
    localparam logic [START_W-1:0] RST_FREQ_START  = START_W'(0);
    localparam logic [STEP_W-1:0]  RST_FREQ_STEP   = STEP_W'(16);
    localparam logic [MAX_W-1:0]   RST_MAX_FORMANT = MAX_W'(10);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREQ_START   = 2'd0,
        CFG_FREQ_STEP    = 2'd1,
        CFG_MAX_FORMANTS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [SLOT_W-1:0] slot;
        logic              overflow;
    } t_peak;

endpackage

// ----- hdl/fpp_detect.sv -----
// Column state and second-difference peak detection of the formant peak picker.
`timescale 1ns / 1ps

module fpp_detect
    import fpp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [AMP_W-1:0] i_amplitude,
    input  logic             i_last_bin,
    input  logic [MAX_W-1:0] i_max_formants,
    output logic             o_peak_hit,
    output t_peak            o_peak
);

    logic [AMP_W-1:0]        r_prev_amp, n_prev_amp;
    logic signed [FD_W-1:0]  r_prev_fd, n_prev_fd;
    logic signed [SD_W-1:0]  r_prev_sd, n_prev_sd;
    logic                    r_lowering, n_lowering;
    logic [COUNT_W-1:0]      r_count, n_count;
    logic [BIN_W-1:0]        r_bin_pos, n_bin_pos;

    logic signed [FD_W-1:0]  fd;
    logic signed [SD_W-1:0]  sd;
    logic [LIM_W-1:0]        limit;
    logic                    active;

    always_comb begin
        n_prev_amp = r_prev_amp;
        n_prev_fd  = r_prev_fd;
        n_prev_sd  = r_prev_sd;
        n_lowering = r_lowering;
        n_count    = r_count;
        n_bin_pos  = r_bin_pos;
        fd         = '0;
        sd         = '0;
        o_peak_hit = 1'b0;
        o_peak     = '0;
        active     = r_bin_pos < BIN_W'(MAX_BINS);
        if (LIM_W'(i_max_formants) > LIM_W'(MAX_FORMANT_SLOTS)) begin
            limit = LIM_W'(MAX_FORMANT_SLOTS);
        end else begin
            limit = LIM_W'(i_max_formants);
        end

        if (i_accept) begin
            if (active) begin
                if (r_bin_pos >= BIN_W'(1)) begin
                    fd = $signed({1'b0, i_amplitude}) - $signed({1'b0, r_prev_amp});
                end
                if (r_bin_pos >= BIN_W'(2)) begin
                    sd = SD_W'(fd) - SD_W'(r_prev_fd);
                end
                if (r_bin_pos >= BIN_W'(3)) begin
                    if (sd < r_prev_sd) begin
                        n_lowering = 1'b1;
                    end else if (sd > r_prev_sd) begin
                        if (r_lowering) begin
                            o_peak_hit = 1'b1;
                            if (LIM_W'(r_count) < limit) begin
                                o_peak.index = IDX_W'(r_bin_pos - BIN_W'(3));
                                o_peak.slot  = SLOT_W'(r_count);
                                n_count      = r_count + COUNT_W'(1);
                            end else begin
                                o_peak.overflow = 1'b1;
                            end
                        end
                        n_lowering = 1'b0;
                    end
                end
                n_prev_amp = i_amplitude;
                if (r_bin_pos >= BIN_W'(1)) begin
                    n_prev_fd = fd;
                end
                if (r_bin_pos >= BIN_W'(2)) begin
                    n_prev_sd = sd;
                end
                n_bin_pos = r_bin_pos + BIN_W'(1);
            end
            if (i_last_bin) begin
                n_prev_amp = '0;
                n_prev_fd  = '0;
                n_prev_sd  = '0;
                n_lowering = 1'b0;
                n_count    = '0;
                n_bin_pos  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_amp <= '0;
            r_prev_fd  <= '0;
            r_prev_sd  <= '0;
            r_lowering <= 1'b0;
            r_count    <= '0;
            r_bin_pos  <= '0;
        end else begin
            r_prev_amp <= n_prev_amp;
            r_prev_fd  <= n_prev_fd;
            r_prev_sd  <= n_prev_sd;
            r_lowering <= n_lowering;
            r_count    <= n_count;
            r_bin_pos  <= n_bin_pos;
        end
    end

endmodule

// ----- hdl/formant_peak_picker.sv -----
// Top level of the formant peak picker: configuration, result pipeline and checks.
// Usage:
// The input channel carries one spectrum bin per word (i_amplitude, i_last_bin),
// moved when i_in_valid is high and o_in_stall is low. i_last_bin marks the final
// bin of a column and restarts the column state after that bin.
// The output channel carries one word per detected peak (o_formant_frequency,
// o_formant_slot, o_overflow), moved when o_out_valid is high and i_out_stall is low.
// Most bins produce no output word; a peak beyond the column limit produces one
// word with o_overflow set and zero frequency and slot.
// Throughput is one bin per cycle while o_in_stall is low. A peak from the bin that
// reveals it passes through two registers: detection into the peak register, then
// the frequency multiply-add into the output register.
// When the receiver stalls, the output register holds its word and the peak register
// keeps accepting bins until it holds a waiting peak; only then is o_in_stall raised.
// Synchronous reset clears the column state and both pipeline stages and loads the
// register defaults: frequency start 0, step 16, limit 10 formants per column.
// Configuration writes act next cycle; the user, not the block, keeps them to idle.
`timescale 1ns / 1ps
`include "formant_peak_picker_macros.svh"

module formant_peak_picker
    import fpp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [AMP_W-1:0]     i_amplitude,
    input  logic                 i_last_bin,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [FREQ_W-1:0]    o_formant_frequency,
    output logic [SLOT_W-1:0]    o_formant_slot,
    output logic                 o_overflow
);

    logic [START_W-1:0] r_freq_start;
    logic [STEP_W-1:0]  r_freq_step;
    logic [MAX_W-1:0]   r_max_formants;

    logic               r_s1_valid;
    t_peak              r_s1;
    logic               r_out_valid;
    logic [FREQ_W-1:0]  r_freq;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_ovf;

    logic               in_accept;
    logic               out_load;
    logic               s1_load;
    logic               peak_hit;
    t_peak              peak;
    logic [PROD_W-1:0]  prod;
    logic [SUM_W-1:0]   sum;
    logic [FREQ_W-1:0]  n_freq;

    assign out_load   = !r_out_valid || !i_out_stall;
    assign s1_load    = !r_s1_valid || out_load;
    assign o_in_stall = !s1_load;
    assign in_accept  = i_in_valid && s1_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_start   <= RST_FREQ_START;
            r_freq_step    <= RST_FREQ_STEP;
            r_max_formants <= RST_MAX_FORMANT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FREQ_START:   r_freq_start   <= START_W'(i_cfg_data);
                CFG_FREQ_STEP:    r_freq_step    <= STEP_W'(i_cfg_data);
                CFG_MAX_FORMANTS: r_max_formants <= MAX_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    fpp_detect u_detect (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_amplitude    (i_amplitude),
        .i_last_bin     (i_last_bin),
        .i_max_formants (r_max_formants),
        .o_peak_hit     (peak_hit),
        .o_peak         (peak)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= peak_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1 <= peak;
        end
    end

    always_comb begin
        prod = PROD_W'(r_s1.index) * PROD_W'(r_freq_step);
        sum  = SUM_W'(r_freq_start) + SUM_W'(prod);
        if (r_s1.overflow) begin
            n_freq = '0;
        end else if (sum > SUM_W'(FREQ_MAX)) begin
            n_freq = FREQ_MAX;
        end else begin
            n_freq = FREQ_W'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_freq <= n_freq;
            r_slot <= r_s1.slot;
            r_ovf  <= r_s1.overflow;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_formant_frequency = r_freq;
    assign o_formant_slot      = r_slot;
    assign o_overflow          = r_ovf;

    `FPP_ASSERT_NOW(a_ovf_word_zero, r_out_valid && r_ovf, (r_freq == '0) && (r_slot == '0), "overflow word carries a nonzero frequency or slot")
    `FPP_ASSERT_NOW(a_no_stall_when_empty, !r_out_valid || !r_s1_valid, !o_in_stall, "input stalled while the pipeline has room")
    `FPP_ASSERT_NEXT(a_peak_held, r_s1_valid && r_out_valid && i_out_stall, r_s1_valid, "waiting peak dropped during an output stall")
    `FPP_ASSERT_NEXT(a_peak_moves_on, r_s1_valid && out_load, r_out_valid, "peak not moved into the output register")

endmodule

// ----- sim/tb_formant_peak_picker.sv -----
// Self-checking testbench for the formant peak picker: bin stream stimulus and peak checks.
`timescale 1ns / 1ps

module tb_formant_peak_picker
    import fpp_pkg::*;
;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int IDLE_LIMIT   = 2000;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [SLOT_W-1:0] slot;
        logic              ovf;
    } t_peak_word;

    class formant_scoreboard;
        logic [START_W-1:0]     freq_start;
        logic [STEP_W-1:0]      freq_step;
        logic [MAX_W-1:0]       max_formants;
        logic [AMP_W-1:0]       last_amp;
        logic signed [FD_W-1:0] last_fd;
        logic signed [SD_W-1:0] last_sd;
        bit                     falling;
        int unsigned            peak_count;
        int unsigned            bin_pos;
        t_peak_word             pending_peaks[$];
        int                     mismatches;

        function new();
            freq_start   = RST_FREQ_START;
            freq_step    = RST_FREQ_STEP;
            max_formants = RST_MAX_FORMANT;
            mismatches   = 0;
            restart_column();
        endfunction

        function void restart_column();
            last_amp   = '0;
            last_fd    = '0;
            last_sd    = '0;
            falling    = 1'b0;
            peak_count = 0;
            bin_pos    = 0;
        endfunction

        function void set_reg(t_cfg_idx which, logic [CFG_W-1:0] val);
            case (which)
                CFG_FREQ_START:   freq_start   = val[START_W-1:0];
                CFG_FREQ_STEP:    freq_step    = val[STEP_W-1:0];
                CFG_MAX_FORMANTS: max_formants = val[MAX_W-1:0];
                default: ;
            endcase
        endfunction

        // Works out the peak word, if any, that one accepted bin reveals.
        function void note_bin(logic [AMP_W-1:0] amp, logic last);
            logic signed [FD_W-1:0] fd;
            logic signed [SD_W-1:0] sd;
            int unsigned            lim;
            longint unsigned        f;
            t_peak_word             p;
            if (bin_pos < MAX_BINS) begin
                fd = '0;
                sd = '0;
                if (bin_pos >= 1)
                    fd = {1'b0, amp} - {1'b0, last_amp};
                if (bin_pos >= 2)
                    sd = {fd[FD_W-1], fd} - {last_fd[FD_W-1], last_fd};
                if (bin_pos >= 3) begin
                    if (sd < last_sd) begin
                        falling = 1'b1;
                    end else if (sd > last_sd) begin
                        if (falling) begin
                            lim = (max_formants > MAX_FORMANT_SLOTS) ? MAX_FORMANT_SLOTS
                                                                     : max_formants;
                            p = '0;
                            if (peak_count < lim) begin
                                f = 64'(freq_start) + 64'(bin_pos - 3) * 64'(freq_step);
                                p.freq = (f > FREQ_MAX) ? FREQ_MAX : f[FREQ_W-1:0];
                                p.slot = peak_count[SLOT_W-1:0];
                                peak_count++;
                            end else begin
                                p.ovf = 1'b1;
                            end
                            pending_peaks.push_back(p);
                        end
                        falling = 1'b0;
                    end
                end
                last_amp = amp;
                if (bin_pos >= 1)
                    last_fd = fd;
                if (bin_pos >= 2)
                    last_sd = sd;
                bin_pos++;
            end
            if (last)
                restart_column();
        endfunction

        function void check_peak(logic [FREQ_W-1:0] freq, logic [SLOT_W-1:0] slot, logic ovf);
            t_peak_word p;
            if (pending_peaks.size() == 0) begin
                $error("Output word with no peak pending: frequency %0d slot %0d overflow %0d",
                       freq, slot, ovf);
                mismatches++;
                return;
            end
            p = pending_peaks.pop_front();
            if (freq !== p.freq) begin
                $error("formant_frequency: expected %0d, got %0d", p.freq, freq);
                mismatches++;
            end
            if (slot !== p.slot) begin
                $error("formant_slot: expected %0d, got %0d", p.slot, slot);
                mismatches++;
            end
            if (ovf !== p.ovf) begin
                $error("overflow: expected %0d, got %0d", p.ovf, ovf);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_peaks.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [AMP_W-1:0]     i_amplitude;
    logic                 i_last_bin;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [FREQ_W-1:0]    o_formant_frequency;
    logic [SLOT_W-1:0]    o_formant_slot;
    logic                 o_overflow;

    formant_peak_picker dut (.*);

    formant_scoreboard sb = new();
    int                burst_left = 0;
    bit                hold_req = 1'b0;
    int                idle_cycles = 0;
    logic [AMP_W:0]    directed_bins [18];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_peak(o_formant_frequency, o_formant_slot, o_overflow);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int mode;
        int len;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
                hold_req = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(5, 60);
                repeat (len) begin
                    @(negedge i_clk);
                    case (mode)
                        0: i_out_stall <= 1'b0;
                        1: i_out_stall <= 1'($urandom_range(0, 1));
                        2: i_out_stall <= ($urandom_range(0, 3) != 0);
                        default: i_out_stall <= ~i_out_stall;
                    endcase
                end
            end
        end
    end

    task automatic idle_sender(int n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    task automatic send_bin(logic [AMP_W-1:0] amp, logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            idle_sender(gap);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_amplitude <= amp;
        i_last_bin  <= last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_bin(amp, last);
    endtask

    task automatic send_column(int len, int mode);
        int a;
        int slope;
        int base;
        a     = $urandom_range(0, 65535);
        base  = $urandom_range(0, 65532);
        slope = 0;
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: a = $urandom_range(0, 65535);
                1: a = base + $urandom_range(0, 3);
                2: begin
                    if ($urandom_range(0, 3) == 0)
                        slope = int'($urandom_range(0, 4000)) - 2000;
                    a = a + slope;
                    if (a < 0)
                        a = 0;
                    if (a > 65535)
                        a = 65535;
                end
                3: a = $urandom_range(0, 1) ? 65535 : 0;
                default: begin
                    if ($urandom_range(0, 4) == 0)
                        a = $urandom_range(0, 65535);
                end
            endcase
            send_bin(a[AMP_W-1:0], i == len - 1);
        end
    endtask

    task automatic random_columns(int n_bins);
        int sent;
        int len;
        sent = 0;
        while (sent < n_bins) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 40);
            send_column(len, $urandom_range(0, 4));
            sent += len;
        end
    endtask

    task automatic drain_pipeline();
        idle_sender(1);
        while (sb.outstanding() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(t_cfg_idx which, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.set_reg(which, val);
    endtask

    // Upper data bits above the step and limit registers' widths carry noise.
    task automatic write_config(logic [START_W-1:0] start, logic [STEP_W-1:0] step,
                                logic [MAX_W-1:0] limit);
        put_reg(CFG_FREQ_START, start);
        put_reg(CFG_FREQ_STEP, {4'($urandom), step});
        put_reg(CFG_MAX_FORMANTS, {15'($urandom), limit});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_FREQ_START;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_amplitude = '0;
        i_last_bin  = 1'b0;
        directed_bins = '{
            {1'b1, 16'hFFFF},
            {1'b0, 16'h0000}, {1'b1, 16'hFFFF},
            {1'b0, 16'h0000}, {1'b0, 16'hFFFF}, {1'b0, 16'h0000}, {1'b0, 16'hFFFF},
            {1'b0, 16'h0000}, {1'b0, 16'hFFFF}, {1'b1, 16'h0000},
            {1'b0, 16'd10}, {1'b0, 16'd10}, {1'b0, 16'd10}, {1'b0, 16'd20},
            {1'b0, 16'd20}, {1'b0, 16'd10}, {1'b0, 16'd10}, {1'b1, 16'd10}
        };
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_bins[i])
            send_bin(directed_bins[i][AMP_W-1:0], directed_bins[i][AMP_W]);
        random_columns(40);

        drain_pipeline();
        write_config('1, '1, MAX_W'(MAX_FORMANT_SLOTS));
        hold_req = 1'b1;
        random_columns(100);

        drain_pipeline();
        write_config('0, '0, MAX_W'(1));
        random_columns(10);

        drain_pipeline();
        write_config(START_W'($urandom), STEP_W'($urandom), '0);
        random_columns(10);

        drain_pipeline();
        write_config(START_W'($urandom), STEP_W'($urandom), '1);
        random_columns(10);

        repeat (2) begin
            drain_pipeline();
            write_config(START_W'($urandom), STEP_W'($urandom),
                         MAX_W'($urandom_range(1, MAX_FORMANT_SLOTS)));
            random_columns(10);
        end

        drain_pipeline();
        write_config('1, '1, MAX_W'(MAX_FORMANT_SLOTS));
        send_column(MAX_BINS + 6, 2);
        random_columns(10);

        drain_pipeline();
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
